// ===== src/sha256_pkg.sv =====
package sha256_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  LEN_POS     = 6'd56;

    typedef logic [31:0] t_word;

    localparam t_word ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Byte source selected by the controller for the block buffer.
    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_PAD  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    typedef struct packed {
        logic       wr_byte;     // write one byte into the block buffer
        logic [1:0] byte_src;
        logic       add_len;     // count eight more message bits
        logic       start_blk;   // load working words from the hash state
        logic       do_round;    // run one compression round
        logic       fold;        // add working words into the hash state
        logic       init;        // reload initial hash values and zero count
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;         // next byte position in the block
        logic [5:0] round;
    } t_status;

endpackage

// ===== src/sha256_ctrl.sv =====
module sha256_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_mode,
    output logic                  o_in_ready,
    input  logic                  i_out_free,
    output logic                  o_out_load,
    output logic [2:0]            o_out_index,
    input  sha256_pkg::t_status   i_status,
    output sha256_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_fin, n_fin;       // finishing: padding in progress
    logic       r_len, n_len;       // length bytes being written
    logic [2:0] r_cnt, n_cnt;       // emit index or length byte index

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin   <= 1'b0;
            r_len   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_index = r_cnt;

    always_comb begin
        n_state    = r_state;
        n_fin      = r_fin;
        n_len      = r_len;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.wr_byte = 1'b1;
                    if (i_in_mode) begin
                        o_cmd.byte_src = sha256_pkg::SRC_PAD;
                        n_fin = 1'b1;
                        n_len = 1'b0;
                        n_cnt = '0;
                        n_state = ST_PAD;
                    end else begin
                        o_cmd.byte_src = sha256_pkg::SRC_DATA;
                        o_cmd.add_len  = 1'b1;
                    end
                    if (i_status.pos == 6'd63) begin
                        o_cmd.start_blk = 1'b1;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.do_round = 1'b1;
                if (i_status.round == 6'd63) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_len) begin
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                o_cmd.wr_byte = 1'b1;
                if (r_len || i_status.pos == sha256_pkg::LEN_POS) begin
                    o_cmd.byte_src = sha256_pkg::SRC_LEN;
                    n_len = 1'b1;
                    n_cnt = r_cnt + 3'd1;
                end else begin
                    o_cmd.byte_src = sha256_pkg::SRC_ZERO;
                end
                if (i_status.pos == 6'd63) begin
                    o_cmd.start_blk = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        o_cmd.init = 1'b1;
                        n_fin   = 1'b0;
                        n_len   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== src/sha256_dpath.sv =====
module sha256_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_data_byte,
    input  logic [2:0]            i_len_index,
    input  logic [2:0]            i_out_index,
    input  sha256_pkg::t_cmd      i_cmd,
    output sha256_pkg::t_status   o_status,
    output logic [31:0]           o_hash_word
);

    // The block is held as sixteen big-endian words; byte 0 sits in the top lane.
    logic [31:0] r_block [0:15];
    logic [31:0] r_h [0:7];
    logic [31:0] r_v [0:7];
    logic [31:0] r_w [0:15];
    logic [63:0] r_len;
    logic [5:0]  r_round;
    logic [5:0]  r_pos;
    logic [7:0]  byte_in;
    logic [31:0] w_new, t1, t2, x2, x15, s0, s1, e, a;
    logic [63:0] len_sh;
    logic [3:0]  w_idx;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Length bytes are written most significant first.
    assign len_sh = r_len << {i_len_index, 3'b000};

    always_comb begin
        case (i_cmd.byte_src)
            sha256_pkg::SRC_DATA: byte_in = i_data_byte;
            sha256_pkg::SRC_PAD:  byte_in = sha256_pkg::PAD_BYTE;
            sha256_pkg::SRC_ZERO: byte_in = 8'h00;
            sha256_pkg::SRC_LEN:  byte_in = len_sh[63:56];
            default:              byte_in = 8'h00;
        endcase
    end

    assign w_idx = r_round[3:0];
    assign x2    = r_w[w_idx - 4'd2];
    assign x15   = r_w[w_idx - 4'd15];
    assign s1    = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    assign s0    = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    assign a     = r_v[0];
    assign e     = r_v[4];

    always_comb begin
        if (r_round < 6'd16) begin
            w_new = r_block[w_idx];
        end else begin
            w_new = s1 + r_w[w_idx - 4'd7] + s0 + r_w[w_idx];
        end
    end

    assign t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + sha256_pkg::ROUND_K[r_round] + w_new;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_block[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= byte_in;
        end
        if (i_cmd.do_round) begin
            r_w[w_idx] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (i_cmd.start_blk) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha256_pkg::INIT_H[i];
            end
            r_len   <= '0;
            r_round <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.wr_byte) begin
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.add_len) begin
                r_len <= r_len + 64'd8;
            end
            if (i_cmd.do_round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.init) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= sha256_pkg::INIT_H[i];
                end
                r_len <= '0;
                r_pos <= '0;
            end
        end
    end

    assign o_status.pos   = r_pos;
    assign o_status.round = r_round;
    assign o_hash_word    = r_h[i_out_index];

endmodule

// ===== src/sha256_hash_engine_core.sv =====
// Channel  | Direction | Signals                      | Contents
// s_axis   | in        | tvalid tready tdata tuser    | tdata: data_byte; tuser: mode
// m_axis   | out       | tvalid tready tdata tuser tlast | tdata: digest_word;
//          |           |                              | tuser: word_index; tlast: last_word
//
// A data byte is taken while the core is idle. The byte that fills a block runs the
// compression rounds on the single round unit and then folds the result into the
// hash state. A finish byte pads one byte per cycle, runs one or two compressions and
// loads eight digest words, one per cycle while the output register is free; a stalled
// sink holds the current word and pauses the rest. Reset is synchronous, active low;
// input waits until the eighth word is loaded.
module sha256_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    sha256_pkg::t_cmd    cmd;
    sha256_pkg::t_status status;
    logic        out_load;
    logic [2:0]  out_index;
    logic [31:0] hash_word;
    logic        out_free;
    logic        r_valid;
    logic [31:0] r_data;
    logic [2:0]  r_index;

    // The output register is free when empty or being drained this cycle.
    assign out_free = !r_valid || m_axis_tready;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_free  (out_free),
        .o_out_load  (out_load),
        .o_out_index (out_index),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sha256_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (s_axis_tdata),
        .i_len_index (out_index),
        .i_out_index (out_index),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_hash_word (hash_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_data  <= hash_word;
            r_index <= out_index;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tuser  = r_index;
    assign m_axis_tlast  = (r_index == 3'd7);

endmodule
